>>> sv/abc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive bitrate controller package
// Shared widths, register indexes, reset values and the structures that
// travel between the register file, the sequencer and the divider.
// ----------------------------------------------------------------------------
package abc_pkg;

  // Field widths.
  localparam int unsigned RATE_W = 30;
  localparam int unsigned RX_W   = 16;
  localparam int unsigned NK_W   = 16;
  localparam int unsigned FR_W   = 10;

  // Packet total and divider operand widths.
  localparam int unsigned DEN_W = RX_W + 1;
  localparam int unsigned DIV_W = RATE_W + RX_W;

  // Configuration port.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned IDX_W  = 2;

  // Default thresholds for the boost counters.
  localparam int unsigned THRESHOLD_MIN_DEF = 5;
  localparam int unsigned THRESHOLD_MAX_DEF = 1024;

  // Scaling constants: a boost is *21/20, the average and the clamp reload
  // divide by five.
  localparam int unsigned BOOST_NUM = 21;
  localparam int unsigned BOOST_DEN = 20;
  localparam int unsigned FIFTH_DEN = 5;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_START_RATE       = 2'd0;
  localparam logic [IDX_W-1:0] REG_START_BURST_RATE = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_RATE         = 2'd2;
  localparam logic [IDX_W-1:0] REG_MIN_RATE         = 2'd3;

  // Register reset values.
  localparam logic [RATE_W-1:0] START_RATE_RST       = RATE_W'(16000000);
  localparam logic [RATE_W-1:0] START_BURST_RATE_RST = RATE_W'(100000000);
  localparam logic [RATE_W-1:0] MAX_RATE_RST         = RATE_W'(30000000);
  localparam logic [RATE_W-1:0] MIN_RATE_RST         = RATE_W'(2000000);

  // Current configuration.
  typedef struct packed {
    logic [RATE_W-1:0] start_rate;
    logic [RATE_W-1:0] start_burst_rate;
    logic [RATE_W-1:0] max_rate;
    logic [RATE_W-1:0] min_rate;
  } cfg_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Finished result from the sequencer.
  typedef struct packed {
    logic              valid;
    logic [RATE_W-1:0] bitrate;
    logic [RATE_W-1:0] burst_rate;
  } res_t;

endpackage
`default_nettype wire

>>> sv/abc_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the start, burst, maximum and minimum
// rates. Writes complete in the access phase; pready is tied high.
// ----------------------------------------------------------------------------
module abc_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [abc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [abc_pkg::DATA_W-1:0]  pwdata,
  output logic      [abc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output abc_pkg::cfg_t                    cfg_o
);

  abc_pkg::cfg_t                  cfg_q;
  logic [abc_pkg::IDX_W-1:0]      idx;
  logic [abc_pkg::RATE_W-1:0]     wval;
  logic [abc_pkg::RATE_W-1:0]     rval;
  logic                           wr_en;

  assign idx    = paddr[abc_pkg::ADDR_W-1:2];
  assign wval   = pwdata[abc_pkg::RATE_W-1:0];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_rate       <= abc_pkg::START_RATE_RST;
      cfg_q.start_burst_rate <= abc_pkg::START_BURST_RATE_RST;
      cfg_q.max_rate         <= abc_pkg::MAX_RATE_RST;
      cfg_q.min_rate         <= abc_pkg::MIN_RATE_RST;
    end else if (wr_en) begin
      case (idx)
        abc_pkg::REG_START_RATE:       cfg_q.start_rate       <= wval;
        abc_pkg::REG_START_BURST_RATE: cfg_q.start_burst_rate <= wval;
        abc_pkg::REG_MAX_RATE:         cfg_q.max_rate         <= wval;
        abc_pkg::REG_MIN_RATE:         cfg_q.min_rate         <= wval;
        default: ;
      endcase
    end
  end

  // Read-back.
  always_comb begin
    case (idx)
      abc_pkg::REG_START_RATE:       rval = cfg_q.start_rate;
      abc_pkg::REG_START_BURST_RATE: rval = cfg_q.start_burst_rate;
      abc_pkg::REG_MAX_RATE:         rval = cfg_q.max_rate;
      abc_pkg::REG_MIN_RATE:         rval = cfg_q.min_rate;
      default:                       rval = '0;
    endcase
  end

  assign prdata = abc_pkg::DATA_W'(rval);

endmodule
`default_nettype wire

>>> sv/abc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle. A request is taken when
// start is high; done pulses for one cycle with the quotient after the last step.
// ----------------------------------------------------------------------------
module abc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire abc_pkg::div_req_t req_i,
  output abc_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(abc_pkg::DIV_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [abc_pkg::DEN_W-1:0]     rem_q, rem_d;
  logic [abc_pkg::DEN_W-1:0]     dvs_q, dvs_d;
  logic [abc_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [abc_pkg::DEN_W:0]       shifted;
  logic [abc_pkg::DEN_W:0]       diff;
  logic                          ge;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign shifted = {rem_q, quo_q[abc_pkg::DIV_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = ge ? diff[abc_pkg::DEN_W-1:0] : shifted[abc_pkg::DEN_W-1:0];
      quo_d = {quo_q[abc_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(abc_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

>>> sv/abc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitrate sequencer
// Holds the throughput and burst state and steps through one statistics
// item, handing every division to the shared divider.
// ----------------------------------------------------------------------------
module abc_ctrl #(
  parameter int unsigned THRESHOLD_MIN = abc_pkg::THRESHOLD_MIN_DEF,
  parameter int unsigned THRESHOLD_MAX = abc_pkg::THRESHOLD_MAX_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire abc_pkg::cfg_t                 cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          stats_valid_i,
  input  wire logic [abc_pkg::RX_W-1:0]      received_packets_i,
  input  wire logic [abc_pkg::NK_W-1:0]      nack_count_i,
  input  wire logic [abc_pkg::FR_W-1:0]      rendered_frames_i,
  output abc_pkg::div_req_t                  div_req_o,
  input  wire abc_pkg::div_rsp_t             div_rsp_i,
  input  wire logic                          out_free_i,
  output abc_pkg::res_t                      res_o
);

  localparam int unsigned RW     = abc_pkg::RATE_W;
  localparam int unsigned TH_TOP = (THRESHOLD_MIN > THRESHOLD_MAX) ? THRESHOLD_MIN
                                                                   : THRESHOLD_MAX;
  localparam int unsigned CNT_W  = $clog2(TH_TOP + 1);
  localparam int unsigned BCNT_W = $clog2(THRESHOLD_MIN + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_TPUT,
    ST_DIV_REAL,
    ST_DIV_BOOST,
    ST_DIV_EWMA,
    ST_CLAMP,
    ST_DIV_CLAMP,
    ST_BURST,
    ST_DIV_BURST,
    ST_BCLAMP,
    ST_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic                       started_q, started_d;
  logic [RW-1:0]              exp_q, exp_d;
  logic [CNT_W-1:0]           match_q, match_d;
  logic [CNT_W-1:0]           bth_q, bth_d;
  logic [RW-1:0]              good_q, good_d;
  logic                       good_v_q, good_v_d;
  logic [CNT_W-1:0]           gth_q, gth_d;
  logic [RW-1:0]              held_q, held_d;
  logic [RW-1:0]              burst_q, burst_d;
  logic [BCNT_W-1:0]          bcnt_q, bcnt_d;
  logic [RW:0]                btmp_q, btmp_d;
  abc_pkg::div_req_t          div_q, div_d;

  // Item latches.
  logic                       sv_q, sv_d;
  logic                       fr_nz_q, fr_nz_d;
  logic [abc_pkg::RX_W-1:0]   rx_q, rx_d;
  logic [abc_pkg::NK_W-1:0]   nk_q, nk_d;

  // Arithmetic around the divider.
  logic [abc_pkg::DEN_W-1:0]  den;
  logic [abc_pkg::DIV_W-1:0]  prod;
  logic [RW+4:0]              exp_x21;
  logic [RW+4:0]              burst_x21;
  logic [RW+2:0]              exp_x5;
  logic [RW:0]                rate;
  logic [RW-1:0]              real_now;
  logic [RW+2:0]              ewma_sum;
  logic [CNT_W-1:0]           match_inc;
  logic [BCNT_W-1:0]          bcnt_inc;
  logic [CNT_W:0]             gth_x2;
  logic [CNT_W-1:0]           gth_cap;
  logic                       accept;

  assign accept    = in_valid_i & in_ready_o;
  assign den       = abc_pkg::DEN_W'(rx_q) + abc_pkg::DEN_W'(nk_q);
  assign prod      = abc_pkg::DIV_W'(exp_q) * abc_pkg::DIV_W'(rx_q);
  assign exp_x21   = (RW+5)'(exp_q) * (RW+5)'(abc_pkg::BOOST_NUM);
  assign burst_x21 = (RW+5)'(burst_q) * (RW+5)'(abc_pkg::BOOST_NUM);
  assign exp_x5    = (RW+3)'(exp_q) * (RW+3)'(abc_pkg::FIFTH_DEN);
  assign rate      = exp_x5[RW+2:2];
  assign real_now  = div_rsp_i.quotient[RW-1:0];
  assign ewma_sum  = (RW+3)'({exp_q, 2'b00}) + (RW+3)'(real_now);
  assign match_inc = match_q + 1'b1;
  assign bcnt_inc  = bcnt_q + 1'b1;
  assign gth_x2    = {gth_q, 1'b0};
  assign gth_cap   = (gth_x2 > (CNT_W+1)'(THRESHOLD_MAX)) ? CNT_W'(THRESHOLD_MAX)
                                                          : gth_x2[CNT_W-1:0];

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer next-state logic.
  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    exp_d     = exp_q;
    match_d   = match_q;
    bth_d     = bth_q;
    good_d    = good_q;
    good_v_d  = good_v_q;
    gth_d     = gth_q;
    held_d    = held_q;
    burst_d   = burst_q;
    bcnt_d    = bcnt_q;
    btmp_d    = btmp_q;
    sv_d      = sv_q;
    fr_nz_d   = fr_nz_q;
    rx_d      = rx_q;
    nk_d      = nk_q;
    div_d     = div_q;
    div_d.start = 1'b0;

    case (state_q)
      // Wait for an item and latch it.
      ST_IDLE: begin
        if (accept) begin
          sv_d    = stats_valid_i;
          fr_nz_d = (rendered_frames_i != '0);
          rx_d    = received_packets_i;
          nk_d    = nack_count_i;
          if (!stats_valid_i) begin
            state_d = ST_DONE;
          end else if (!started_q) begin
            div_d.start    = 1'b1;
            div_d.dividend = abc_pkg::DIV_W'({cfg_i.start_rate, 2'b00});
            div_d.divisor  = abc_pkg::DEN_W'(abc_pkg::FIFTH_DEN);
            state_d        = ST_START;
          end else begin
            state_d = ST_TPUT;
          end
        end
      end

      // First valid item: load the state from the registers.
      ST_START: begin
        if (div_rsp_i.done) begin
          exp_d     = div_rsp_i.quotient[RW-1:0];
          held_d    = cfg_i.start_rate;
          burst_d   = cfg_i.start_burst_rate;
          started_d = 1'b1;
          state_d   = ST_TPUT;
        end
      end

      // Scale the expected throughput by the received fraction.
      ST_TPUT: begin
        if (den != '0) begin
          div_d.start    = 1'b1;
          div_d.dividend = prod;
          div_d.divisor  = den;
          state_d        = ST_DIV_REAL;
        end else begin
          state_d = ST_BURST;
        end
      end

      // Compare the measured throughput with the expectation.
      ST_DIV_REAL: begin
        if (div_rsp_i.done) begin
          if (real_now == exp_q) begin
            if (match_inc >= bth_q) begin
              good_d         = real_now;
              good_v_d       = 1'b1;
              match_d        = '0;
              gth_d          = bth_q;
              bth_d          = CNT_W'(THRESHOLD_MIN);
              div_d.start    = 1'b1;
              div_d.dividend = abc_pkg::DIV_W'(exp_x21);
              div_d.divisor  = abc_pkg::DEN_W'(abc_pkg::BOOST_DEN);
              state_d        = ST_DIV_BOOST;
            end else begin
              match_d = match_inc;
              state_d = ST_CLAMP;
            end
          end else begin
            match_d = '0;
            if (good_v_q && (exp_q > good_q)) begin
              exp_d   = good_q;
              gth_d   = gth_cap;
              bth_d   = gth_cap;
              state_d = ST_CLAMP;
            end else begin
              bth_d          = CNT_W'(THRESHOLD_MIN);
              div_d.start    = 1'b1;
              div_d.dividend = abc_pkg::DIV_W'(ewma_sum);
              div_d.divisor  = abc_pkg::DEN_W'(abc_pkg::FIFTH_DEN);
              state_d        = ST_DIV_EWMA;
            end
          end
        end
      end

      // Boosted or averaged throughput comes back from the divider.
      ST_DIV_BOOST, ST_DIV_EWMA: begin
        if (div_rsp_i.done) begin
          exp_d   = div_rsp_i.quotient[RW-1:0];
          state_d = ST_CLAMP;
        end
      end

      // Bitrate is 5/4 of the throughput, capped first, then floored.
      ST_CLAMP: begin
        if (rate > (RW+1)'(cfg_i.max_rate)) begin
          held_d         = cfg_i.max_rate;
          div_d.start    = 1'b1;
          div_d.dividend = abc_pkg::DIV_W'({cfg_i.max_rate, 2'b00});
          div_d.divisor  = abc_pkg::DEN_W'(abc_pkg::FIFTH_DEN);
          state_d        = ST_DIV_CLAMP;
        end else if (rate < (RW+1)'(cfg_i.min_rate)) begin
          held_d         = cfg_i.min_rate;
          div_d.start    = 1'b1;
          div_d.dividend = abc_pkg::DIV_W'({cfg_i.min_rate, 2'b00});
          div_d.divisor  = abc_pkg::DEN_W'(abc_pkg::FIFTH_DEN);
          state_d        = ST_DIV_CLAMP;
        end else begin
          held_d  = rate[RW-1:0];
          state_d = ST_BURST;
        end
      end

      ST_DIV_CLAMP: begin
        if (div_rsp_i.done) begin
          exp_d   = div_rsp_i.quotient[RW-1:0];
          state_d = ST_BURST;
        end
      end

      // Burst rate counts periods with rendered frames and boosts.
      ST_BURST: begin
        if (!fr_nz_q) begin
          state_d = ST_DONE;
        end else if (bcnt_inc >= BCNT_W'(THRESHOLD_MIN)) begin
          bcnt_d         = '0;
          div_d.start    = 1'b1;
          div_d.dividend = abc_pkg::DIV_W'(burst_x21);
          div_d.divisor  = abc_pkg::DEN_W'(abc_pkg::BOOST_DEN);
          state_d        = ST_DIV_BURST;
        end else begin
          bcnt_d  = bcnt_inc;
          btmp_d  = (RW+1)'(burst_q);
          state_d = ST_BCLAMP;
        end
      end

      ST_DIV_BURST: begin
        if (div_rsp_i.done) begin
          btmp_d  = div_rsp_i.quotient[RW:0];
          state_d = ST_BCLAMP;
        end
      end

      // Cap at the start burst rate first; the floor only applies otherwise.
      ST_BCLAMP: begin
        if (btmp_q > (RW+1)'(cfg_i.start_burst_rate)) begin
          burst_d = cfg_i.start_burst_rate;
        end else if (btmp_q < (RW+1)'(cfg_i.min_rate)) begin
          burst_d = cfg_i.min_rate;
        end else begin
          burst_d = btmp_q[RW-1:0];
        end
        state_d = ST_DONE;
      end

      // Hand the result to the output register.
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      exp_q       <= '0;
      match_q     <= '0;
      bth_q       <= CNT_W'(THRESHOLD_MIN);
      good_q      <= '0;
      good_v_q    <= 1'b0;
      gth_q       <= CNT_W'(THRESHOLD_MIN);
      held_q      <= abc_pkg::START_RATE_RST;
      burst_q     <= abc_pkg::START_BURST_RATE_RST;
      bcnt_q      <= '0;
      div_q       <= '0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      exp_q       <= exp_d;
      match_q     <= match_d;
      bth_q       <= bth_d;
      good_q      <= good_d;
      good_v_q    <= good_v_d;
      gth_q       <= gth_d;
      held_q      <= held_d;
      burst_q     <= burst_d;
      bcnt_q      <= bcnt_d;
      div_q       <= div_d;
    end
  end

  // Item latches need no reset.
  always_ff @(posedge clk_i) begin
    sv_q           <= sv_d;
    fr_nz_q        <= fr_nz_d;
    rx_q           <= rx_d;
    nk_q           <= nk_d;
    btmp_q         <= btmp_d;
  end

  assign div_req_o = div_q;

  // Without valid statistics the configured defaults are returned.
  assign res_o.valid      = (state_q == ST_DONE);
  assign res_o.bitrate    = sv_q ? held_q  : cfg_i.start_rate;
  assign res_o.burst_rate = sv_q ? burst_q : cfg_i.start_burst_rate;

  // A division request is only out while the sequencer waits for its answer.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q.start |-> (state_q == ST_START || state_q == ST_DIV_REAL ||
                     state_q == ST_DIV_BOOST || state_q == ST_DIV_EWMA ||
                     state_q == ST_DIV_CLAMP || state_q == ST_DIV_BURST))
    else $error("divider started outside a waiting state");

  // The divider never answers a state that is not waiting.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == ST_START || state_q == ST_DIV_REAL ||
                        state_q == ST_DIV_BOOST || state_q == ST_DIV_EWMA ||
                        state_q == ST_DIV_CLAMP || state_q == ST_DIV_BURST))
    else $error("divider answer with no state waiting");

  // The match count stays below the boost threshold.
  a_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q < bth_q)
    else $error("match count reached the boost threshold");

  // The burst count wraps before the threshold.
  a_bcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q < BCNT_W'(THRESHOLD_MIN))
    else $error("burst count reached the threshold");

  // Once started, the state is never reloaded.
  a_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

endmodule
`default_nettype wire

>>> sv/adaptive_bitrate_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// An item without valid statistics goes from idle straight to the done state, then to the
// output register; otherwise it passes the throughput, clamp (if it has packets), burst
// and burst clamp (if it has frames) states, with D (0 to 5) shared divider passes.
// Throughput: one item at a time; in_ready_o is low while the sequencer works.
// The output register lets the next item start while a result awaits out_ready_i.
// Reset: asynchronous, active low; registers return to their defaults, state clears.
// ----------------------------------------------------------------------------
// Adaptive bitrate controller
// Turns per-period packet and frame statistics into a requested bitrate and
// burst bitrate, with an APB-style configuration port.
// ----------------------------------------------------------------------------
module adaptive_bitrate_controller #(
  parameter int unsigned THRESHOLD_MIN = abc_pkg::THRESHOLD_MIN_DEF,
  parameter int unsigned THRESHOLD_MAX = abc_pkg::THRESHOLD_MAX_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [abc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [abc_pkg::DATA_W-1:0]   pwdata,
  output logic      [abc_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  // Statistics input
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         stats_valid_i,
  input  wire logic [abc_pkg::RX_W-1:0]     received_packets_i,
  input  wire logic [abc_pkg::NK_W-1:0]     nack_count_i,
  input  wire logic [abc_pkg::FR_W-1:0]     rendered_frames_i,
  // Rate output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [abc_pkg::RATE_W-1:0]   bitrate_out_o,
  output logic      [abc_pkg::RATE_W-1:0]   burst_rate_out_o
);

  abc_pkg::cfg_t                cfg;
  abc_pkg::div_req_t            div_req;
  abc_pkg::div_rsp_t            div_rsp;
  abc_pkg::res_t                res;
  logic                         out_free;
  logic                         out_valid_q;
  logic [abc_pkg::RATE_W-1:0]   bitrate_q;
  logic [abc_pkg::RATE_W-1:0]   burst_q;

  abc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  abc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  abc_ctrl #(
    .THRESHOLD_MIN (THRESHOLD_MIN),
    .THRESHOLD_MAX (THRESHOLD_MAX)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .stats_valid_i      (stats_valid_i),
    .received_packets_i (received_packets_i),
    .nack_count_i       (nack_count_i),
    .rendered_frames_i  (rendered_frames_i),
    .div_req_o          (div_req),
    .div_rsp_i          (div_rsp),
    .out_free_i         (out_free),
    .res_o              (res)
  );

  // Output register: free when empty or being emptied this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      bitrate_q <= res.bitrate;
      burst_q   <= res.burst_rate;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bitrate_out_o    = bitrate_q;
  assign burst_rate_out_o = burst_q;

endmodule
`default_nettype wire
